FILE: hdl/scr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

  localparam int  WORD_BYTES_DEF       = 8;
  localparam bit  BIG_ENDIAN_LANES_DEF = 1'b0;

  localparam int  DATA_W    = 64;
  localparam int  IDX_W     = 13;
  localparam int  LEN_W     = 16;
  localparam int  OFF_W     = 3;
  // lane counts 0..8, enough for words of up to eight bytes
  localparam int  CNT_W     = 4;
  localparam int  CFG_IDX_W = 2;

  localparam int  QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LENGTH   = 2'd1;

  // One destination word to be produced by the back end
  typedef struct packed {
    logic             vld;
    logic             fin;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] idx;
  } beat_t;

  // Work for one accepted item: up to two destination words
  typedef struct packed {
    beat_t             a;
    beat_t             b;
    logic [DATA_W-1:0] held;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] old;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/scr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scr_front #(
  parameter int WORD_BYTES = scr_pkg::WORD_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scr_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [scr_pkg::DATA_W-1:0]    in_source_data,
  input  wire logic [scr_pkg::DATA_W-1:0]    in_old_destination,
  input  wire logic                          q_full,
  output logic                               push,
  output scr_pkg::cmd_t                      cmd,
  output logic [scr_pkg::OFF_W-1:0]          off
);

  localparam logic [scr_pkg::LEN_W-1:0] WB_LEN   = scr_pkg::LEN_W'(WORD_BYTES);
  localparam logic [scr_pkg::CNT_W-1:0] WB_CNT   = scr_pkg::CNT_W'(WORD_BYTES);
  localparam logic [scr_pkg::OFF_W:0]   WB_OFF_X = (scr_pkg::OFF_W + 1)'(WORD_BYTES);

  logic [scr_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [scr_pkg::LEN_W-1:0] span_r, span_nxt;
  logic [scr_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [scr_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      have_held_r, have_held_nxt;
  logic [scr_pkg::DATA_W-1:0] held_r;

  logic                      accept;
  logic                      a_vld, b_vld, hold;
  logic [scr_pkg::LEN_W-1:0] r1, r1_sat, rem_sat, room;
  logic [scr_pkg::IDX_W-1:0] idx_after_a;
  logic [scr_pkg::OFF_W:0]   off_mod;
  logic                      cfg_hit;

  function automatic logic [scr_pkg::CNT_W-1:0] clip(input logic [scr_pkg::LEN_W-1:0] n);
    return (n >= WB_LEN) ? WB_CNT : n[scr_pkg::CNT_W-1:0];
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign off      = off_r;

  // reduce the low OFF_W bits of the written offset modulo the word width
  always_comb begin
    off_mod = {1'b0, cfg_wdata[scr_pkg::OFF_W-1:0]};
    for (int k = 0; k < 4; k++) begin
      if (off_mod >= WB_OFF_X) begin
        off_mod = off_mod - WB_OFF_X;
      end
    end
  end

  always_comb begin
    rem_sat     = (rem_r >= WB_LEN) ? rem_r - WB_LEN : '0;
    a_vld       = (off_r != '0) && have_held_r && (rem_r != '0);
    r1          = a_vld ? rem_sat : rem_r;
    room        = WB_LEN - scr_pkg::LEN_W'(off_r);
    hold        = (off_r != '0) && (r1 != '0) && (r1 > room);
    b_vld       = (r1 != '0) && !hold;
    r1_sat      = (r1 >= WB_LEN) ? r1 - WB_LEN : '0;
    idx_after_a = a_vld ? idx_r + 1'b1 : idx_r;

    cmd.a.vld = a_vld;
    cmd.a.fin = rem_r <= WB_LEN;
    cmd.a.cnt = clip(rem_r);
    cmd.a.idx = idx_r;
    cmd.b.vld = b_vld;
    cmd.b.fin = r1 <= WB_LEN;
    cmd.b.cnt = clip(r1);
    cmd.b.idx = idx_after_a;
    cmd.held  = held_r;
    cmd.cur   = in_source_data;
    cmd.old   = in_old_destination;

    push = accept && (a_vld || b_vld);
  end

  always_comb begin
    off_nxt       = off_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    have_held_nxt = have_held_r;
    cfg_hit       = cfg_we && (cfg_index == scr_pkg::CFG_SOURCE_OFFSET ||
                               cfg_index == scr_pkg::CFG_SPAN_LENGTH);
    if (cfg_hit) begin
      // a write to either register restarts the transfer
      if (cfg_index == scr_pkg::CFG_SOURCE_OFFSET) begin
        off_nxt = off_mod[scr_pkg::OFF_W-1:0];
        rem_nxt = span_r;
      end else begin
        span_nxt = cfg_wdata;
        rem_nxt  = cfg_wdata;
      end
      idx_nxt       = '0;
      have_held_nxt = 1'b0;
    end else if (accept) begin
      rem_nxt       = hold ? r1 : (b_vld ? r1_sat : r1);
      idx_nxt       = b_vld ? idx_after_a + 1'b1 : idx_after_a;
      have_held_nxt = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      span_r      <= '0;
      rem_r       <= '0;
      idx_r       <= '0;
      have_held_r <= 1'b0;
    end else begin
      off_r       <= off_nxt;
      span_r      <= span_nxt;
      rem_r       <= rem_nxt;
      idx_r       <= idx_nxt;
      have_held_r <= have_held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold && !cfg_hit) begin
      held_r <= in_source_data;
    end
  end

  a_held_needs_offset: assert property (@(posedge clk) disable iff (!rst_n)
    have_held_r |-> (off_r != '0) && (rem_r != '0))
    else $error("held word without offset or remaining bytes");

  a_pair_ends_span: assert property (@(posedge clk) disable iff (!rst_n)
    push && cmd.a.vld && cmd.b.vld |-> cmd.b.fin)
    else $error("two results from one item but second is not final");

endmodule

`default_nettype wire

FILE: hdl/scr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module scr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire scr_pkg::cmd_t wdata,
  output logic               full,
  output logic               rd_valid,
  output scr_pkg::cmd_t      rdata,
  input  wire logic          pop
);

  localparam int DEPTH = scr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  scr_pkg::cmd_t     entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = count_r == FULL_CNT;
  assign rd_valid = count_r != '0;
  assign rdata    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: hdl/scr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module scr_back #(
  parameter int WORD_BYTES       = scr_pkg::WORD_BYTES_DEF,
  parameter bit BIG_ENDIAN_LANES = scr_pkg::BIG_ENDIAN_LANES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire scr_pkg::cmd_t               cmd,
  output logic                             pop,
  input  wire logic [scr_pkg::OFF_W-1:0]   off,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [scr_pkg::DATA_W-1:0]       out_dest_data,
  output logic [scr_pkg::IDX_W-1:0]        out_dest_index,
  output logic                             out_final_word
);

  localparam int W = WORD_BYTES * 8;

  logic                       out_valid_r, out_valid_nxt;
  logic                       sel_b_r, sel_b_nxt;
  logic [scr_pkg::DATA_W-1:0] data_r;
  logic [scr_pkg::IDX_W-1:0]  idx_r;
  logic                       fin_r;

  logic                        load, last_beat, use_b;
  scr_pkg::beat_t              beat;
  logic [W-1:0]                w0, w1, fun, old_w, merged;
  logic [2*W-1:0]              pair;
  logic [scr_pkg::OFF_W+2:0]   shamt;
  int                          pos;

  always_comb begin
    last_beat = !(cmd.a.vld && cmd.b.vld && !sel_b_r);
    use_b     = cmd.b.vld && (!cmd.a.vld || sel_b_r);
    beat      = use_b ? cmd.b : cmd.a;
    w0        = use_b ? cmd.cur[W-1:0] : cmd.held[W-1:0];
    w1        = use_b ? '0 : cmd.cur[W-1:0];
    old_w     = cmd.old[W-1:0];
    shamt     = {off, 3'b000};

    // funnel shift the two neighbouring source words
    if (BIG_ENDIAN_LANES) begin
      pair = {w0, w1} << shamt;
      fun  = pair[2*W-1:W];
    end else begin
      pair = {w1, w0} >> shamt;
      fun  = pair[W-1:0];
    end

    // keep span lanes, take the rest from the old destination word
    for (int i = 0; i < WORD_BYTES; i++) begin
      pos = BIG_ENDIAN_LANES ? WORD_BYTES - 1 - i : i;
      merged[i*8 +: 8] = (beat.cnt > scr_pkg::CNT_W'(pos)) ? fun[i*8 +: 8] : old_w[i*8 +: 8];
    end

    load = q_valid && (!out_valid_r || out_ready);
    pop  = load && last_beat;

    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    sel_b_nxt     = load ? !last_beat : sel_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_b_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_b_r     <= sel_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= scr_pkg::DATA_W'(merged);
      idx_r  <= beat.idx;
      fin_r  <= beat.fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_data  = data_r;
  assign out_dest_index = idx_r;
  assign out_final_word = fin_r;

  a_second_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    load && !last_beat |=> sel_b_r)
    else $error("second result of a paired item not selected");

  a_second_beat_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    sel_b_r |-> q_valid && cmd.a.vld && cmd.b.vld)
    else $error("second-result phase without its paired item");

endmodule

`default_nettype wire

FILE: hdl/span_copy_realigner.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-span copy realigner. Write source_offset (index 0) and span_length (index 1)
// while idle; either write restarts the transfer. Then feed aligned source words in
// address order, with old_destination valid alongside (it is used only for the final
// partial word). The block takes one item per clock whenever its two-entry command queue
// has room, and gives one destination word per clock while out_ready is high. A result is
// written into the queue when its item is accepted and is then loaded into the output
// register, from which it is taken. An item that completes a held word and also ends the
// span yields two results, which leave one after the other through the single output
// register. Items that arrive after the span is finished are taken and dropped.
module span_copy_realigner #(
  parameter int WORD_BYTES       = scr_pkg::WORD_BYTES_DEF,
  parameter bit BIG_ENDIAN_LANES = scr_pkg::BIG_ENDIAN_LANES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scr_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [scr_pkg::DATA_W-1:0]    in_source_data,
  input  wire logic [scr_pkg::DATA_W-1:0]    in_old_destination,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [scr_pkg::DATA_W-1:0]         out_dest_data,
  output logic [scr_pkg::IDX_W-1:0]          out_dest_index,
  output logic                               out_final_word
);

  logic                      push, q_full, q_valid, pop;
  scr_pkg::cmd_t             cmd_in, cmd_out;
  logic [scr_pkg::OFF_W-1:0] off;

  scr_front #(
    .WORD_BYTES (WORD_BYTES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_source_data     (in_source_data),
    .in_old_destination (in_old_destination),
    .q_full             (q_full),
    .push               (push),
    .cmd                (cmd_in),
    .off                (off)
  );

  scr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wdata    (cmd_in),
    .full     (q_full),
    .rd_valid (q_valid),
    .rdata    (cmd_out),
    .pop      (pop)
  );

  scr_back #(
    .WORD_BYTES       (WORD_BYTES),
    .BIG_ENDIAN_LANES (BIG_ENDIAN_LANES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .cmd            (cmd_out),
    .pop            (pop),
    .off            (off),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dest_data  (out_dest_data),
    .out_dest_index (out_dest_index),
    .out_final_word (out_final_word)
  );

endmodule

`default_nettype wire
